/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define SST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cond implies prop at the same edge.
`define SST_ASSERT_IMP(lbl, clk, rstn, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
    else $error(msg);

`endif

/* sv/sst_pkg.sv */
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes of the sorted string table search block.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int unsigned StatusW = 3;

  localparam logic [1:0] ReqClear  = 2'd0;
  localparam logic [1:0] ReqLoad   = 2'd1;
  localparam logic [1:0] ReqSearch = 2'd2;

  localparam logic [StatusW-1:0] StLoaded   = 3'd0;
  localparam logic [StatusW-1:0] StFull     = 3'd1;
  localparam logic [StatusW-1:0] StTooLong  = 3'd2;
  localparam logic [StatusW-1:0] StFound    = 3'd3;
  localparam logic [StatusW-1:0] StNotFound = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_SEARCH
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  key_byte;
    logic        last_byte;
    logic [31:0] entry_value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MID,
    BK_ADDR,
    BK_RD,
    BK_CMP
  } back_state_e;

endpackage

/* sv/sst_ram.sv */
// ----------------------------------------------------------------------------
// sst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/sst_front.sv */
// ----------------------------------------------------------------------------
// sst_front
// Input stage: takes words, decodes the request code, drops unknown codes.
// ----------------------------------------------------------------------------
module sst_front import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  key_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] entry_value_i,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i,
  output cmd_t        cmd_o
);

  logic      vld_q, vld_d;
  cmd_t      cmd_q, cmd_d;
  logic      take;
  logic      known;
  cmd_kind_e kind;

  always_comb begin
    known = 1'b1;
    kind  = CMD_CLEAR;
    unique case (req_type_i)
      ReqClear:  kind = CMD_CLEAR;
      ReqLoad:   kind = CMD_LOAD;
      ReqSearch: kind = CMD_SEARCH;
      default:   known = 1'b0;
    endcase
  end

  assign in_ready_o = !vld_q || cmd_ready_i;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    cmd_d = cmd_q;
    if (vld_q && cmd_ready_i) vld_d = 1'b0;
    if (take && known) begin
      vld_d = 1'b1;
      cmd_d = '{kind: kind, key_byte: key_byte_i, last_byte: last_byte_i,
                entry_value: entry_value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else         vld_q <= vld_d;
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign cmd_valid_o = vld_q;
  assign cmd_o       = cmd_q;

endmodule

/* sv/sst_queue.sv */
// ----------------------------------------------------------------------------
// sst_queue
// Two-entry command queue between the input stage and the search engine.
// ----------------------------------------------------------------------------
module sst_queue import sst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_cmd_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= !wptr_q;
      if (pop)  rptr_q <= !rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_cmd_i;
  end

endmodule

/* sv/sst_back.sv */
// ----------------------------------------------------------------------------
// sst_back
// Search engine: assembles keys, appends loads, binary-searches the table.
// ----------------------------------------------------------------------------
module sst_back import sst_pkg::*; #(
  parameter int unsigned TableEntries = 1024,
  parameter int unsigned MaxKeyLen    = 50
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  input  cmd_t               cmd_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [StatusW-1:0] res_status_o,
  output logic [31:0]        res_value_o
);

  localparam int unsigned IW = $clog2(TableEntries);
  localparam int unsigned CW = $clog2(TableEntries + 1);
  localparam int unsigned LW = CW + 1;
  localparam int unsigned FW = $clog2(MaxKeyLen + 1);
  localparam int unsigned BW = (MaxKeyLen > 1) ? $clog2(MaxKeyLen) : 1;
  localparam int unsigned SD = TableEntries * MaxKeyLen;
  localparam int unsigned SW = $clog2(SD);

  back_state_e state_q, state_d;

  logic [CW-1:0]        count_q, count_d;
  logic [SW-1:0]        lbase_q, lbase_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic                 ovl_q, ovl_d;
  logic signed [LW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0]        mid_q, mid_d;
  logic [SW-1:0]        sbase_q, sbase_d;
  logic [FW-1:0]        idx_q, idx_d;
  logic                 ovld_q, ovld_d;
  logic [StatusW-1:0]   ost_q, ost_d;
  logic [31:0]          oval_q, oval_d;

  logic                 buf_we, st_we, len_we, val_we;
  logic [7:0]           buf_rdata, st_rdata;
  logic [FW-1:0]        len_rdata;
  logic [31:0]          val_rdata;

  logic                 is_key, fill_full, ovl_new, has_room, pop, go_search;
  logic [FW-1:0]        fill_new, n_cmp;
  logic signed [LW-1:0] diff, mid_full, mid_ext;
  logic                 lo_le_hi, at_end, len_eq, len_lt, byte_eq, byte_lt;

  assign is_key    = (cmd_i.kind != CMD_CLEAR);
  assign fill_full = (fill_q >= FW'(MaxKeyLen));
  assign fill_new  = fill_full ? fill_q : fill_q + FW'(1);
  assign ovl_new   = ovl_q || fill_full;
  assign has_room  = (count_q < CW'(TableEntries));
  // a key end needs a free result slot before it starts
  assign pop       = (state_q == BK_IDLE) && cmd_valid_i &&
                     !(is_key && cmd_i.last_byte && ovld_q);
  assign go_search = pop && (cmd_i.kind == CMD_SEARCH) && cmd_i.last_byte &&
                     !ovl_new && (count_q != '0);

  assign diff     = hi_q - lo_q;
  assign mid_full = lo_q + (diff >>> 1);
  assign mid_ext  = $signed({{(LW-IW){1'b0}}, mid_q});
  assign lo_le_hi = (lo_q <= hi_q);
  assign n_cmp    = (len_rdata < fill_q) ? len_rdata : fill_q;
  assign at_end   = (idx_q == n_cmp);
  assign len_eq   = (len_rdata == fill_q);
  assign len_lt   = (len_rdata < fill_q);
  assign byte_eq  = (st_rdata == buf_rdata);
  assign byte_lt  = (st_rdata < buf_rdata);

  assign cmd_pop_o = pop;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: if (go_search) state_d = BK_MID;
      BK_MID:  state_d = lo_le_hi ? BK_ADDR : BK_IDLE;
      BK_ADDR: state_d = BK_RD;
      BK_RD: begin
        if (!at_end)     state_d = BK_CMP;
        else if (len_eq) state_d = BK_IDLE;
        else             state_d = BK_MID;
      end
      BK_CMP:  state_d = byte_eq ? BK_RD : BK_MID;
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    count_d = count_q;
    lbase_d = lbase_q;
    fill_d  = fill_q;
    ovl_d   = ovl_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    sbase_d = sbase_q;
    idx_d   = idx_q;
    ovld_d  = ovld_q;
    ost_d   = ost_q;
    oval_d  = oval_q;
    buf_we  = 1'b0;
    st_we   = 1'b0;
    len_we  = 1'b0;
    val_we  = 1'b0;
    if (ovld_q && res_ready_i) ovld_d = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (pop && !is_key) begin
          count_d = '0;
          lbase_d = '0;
          fill_d  = '0;
          ovl_d   = 1'b0;
        end else if (pop) begin
          buf_we = !fill_full;
          st_we  = !fill_full && has_room;
          fill_d = fill_new;
          ovl_d  = ovl_new;
          if (cmd_i.last_byte) begin
            lo_d = '0;
            hi_d = $signed({1'b0, count_q}) - LW'(1);
            if (!go_search) begin
              fill_d = '0;
              ovl_d  = 1'b0;
              ovld_d = 1'b1;
              oval_d = '0;
              if (cmd_i.kind == CMD_SEARCH) ost_d = StNotFound;
              else if (ovl_new)             ost_d = StTooLong;
              else if (!has_room)           ost_d = StFull;
              else begin
                ost_d   = StLoaded;
                len_we  = 1'b1;
                val_we  = 1'b1;
                count_d = count_q + CW'(1);
                lbase_d = lbase_q + SW'(MaxKeyLen);
              end
            end
          end
        end
      end
      BK_MID: begin
        mid_d = mid_full[IW-1:0];
        if (!lo_le_hi) begin
          fill_d = '0;
          ovld_d = 1'b1;
          ost_d  = StNotFound;
          oval_d = '0;
        end
      end
      BK_ADDR: begin
        sbase_d = SW'(SW'(mid_q) * SW'(MaxKeyLen));
        idx_d   = '0;
      end
      BK_RD: begin
        if (at_end) begin
          if (len_eq) begin
            fill_d = '0;
            ovld_d = 1'b1;
            ost_d  = StFound;
            oval_d = val_rdata;
          end else if (len_lt) begin
            lo_d = mid_ext + LW'(1);
          end else begin
            hi_d = mid_ext - LW'(1);
          end
        end
      end
      BK_CMP: begin
        if (byte_eq)      idx_d = idx_q + FW'(1);
        else if (byte_lt) lo_d  = mid_ext + LW'(1);
        else              hi_d  = mid_ext - LW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      count_q <= '0;
      lbase_q <= '0;
      fill_q  <= '0;
      ovl_q   <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lbase_q <= lbase_d;
      fill_q  <= fill_d;
      ovl_q   <= ovl_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    sbase_q <= sbase_d;
    idx_q   <= idx_d;
    ost_q   <= ost_d;
    oval_q  <= oval_d;
  end

  sst_ram #(.Width(8), .Depth(MaxKeyLen)) u_key_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (fill_q[BW-1:0]),
    .wdata_i (cmd_i.key_byte),
    .raddr_i (idx_q[BW-1:0]),
    .rdata_o (buf_rdata)
  );

  sst_ram #(.Width(8), .Depth(SD)) u_key_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (lbase_q + SW'(fill_q)),
    .wdata_i (cmd_i.key_byte),
    .raddr_i (sbase_q + SW'(idx_q)),
    .rdata_o (st_rdata)
  );

  sst_ram #(.Width(FW), .Depth(TableEntries)) u_key_len (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (fill_new),
    .raddr_i (mid_q),
    .rdata_o (len_rdata)
  );

  sst_ram #(.Width(32), .Depth(TableEntries)) u_values (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (cmd_i.entry_value),
    .raddr_i (mid_q),
    .rdata_o (val_rdata)
  );

  assign res_valid_o  = ovld_q;
  assign res_status_o = ost_q;
  assign res_value_o  = oval_q;

endmodule

/* sv/sorted_string_table_search.sv */
// ----------------------------------------------------------------------------
// sorted_string_table_search
// Byte-string key table with append load and binary search lookup.
// ----------------------------------------------------------------------------
// Key bytes stream in one word per cycle, while no back-pressure holds them,
// through an input register and a two-entry queue. A search key end walks
// the binary search: each probe steps through MID, ADDR and RD, then CMP
// and RD again for each byte compared before a difference, over about
// log2(entries+1) probes, all through the single read port of the key store.
// A key end waits until the previous result word has been taken. No
// clearing pass runs after reset.
module sorted_string_table_search import sst_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 1024,
  parameter int unsigned MAX_KEY_LEN   = 50
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // key_byte[7:0], entry_value[39:8]
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  input  logic        s_axis_tlast_i,  // last_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // found_value[31:0]
  output logic [2:0]  m_axis_tuser_o   // status[2:0]
);

  `include "assert_macros.svh"

  logic fr_valid, fr_ready, q_valid, q_pop;
  cmd_t fr_cmd, q_cmd;

  sst_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .req_type_i    (s_axis_tuser_i),
    .key_byte_i    (s_axis_tdata_i[7:0]),
    .last_byte_i   (s_axis_tlast_i),
    .entry_value_i (s_axis_tdata_i[39:8]),
    .cmd_valid_o   (fr_valid),
    .cmd_ready_i   (fr_ready),
    .cmd_o         (fr_cmd)
  );

  sst_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  sst_back #(
    .TableEntries (TABLE_ENTRIES),
    .MaxKeyLen    (MAX_KEY_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (q_valid),
    .cmd_pop_o    (q_pop),
    .cmd_i        (q_cmd),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_status_o (m_axis_tuser_o),
    .res_value_o  (m_axis_tdata_o)
  );

  `SST_ASSERT_IMP(a_value_only_found, clk_i, rst_ni,
    m_axis_tvalid_o && (m_axis_tuser_o != StFound), m_axis_tdata_o == '0,
    "nonzero value on a result that is not found")
  `SST_ASSERT_IMP(a_status_range, clk_i, rst_ni, m_axis_tvalid_o,
    m_axis_tuser_o <= StNotFound, "status code out of range")
  `SST_ASSERT(a_result_held, clk_i, rst_ni,
    $past(m_axis_tvalid_o && !m_axis_tready_i) |-> m_axis_tvalid_o && $stable(m_axis_tuser_o),
    "stalled result word changed")

endmodule

/* tb/tb_sorted_string_table_search.sv */
// ----------------------------------------------------------------------------
// tb_sorted_string_table_search
// Streams clear, load and search words into the table and checks every
// status word against a behavioral table model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_sorted_string_table_search;
  import sst_pkg::*;

  localparam int unsigned Entries = 1024;
  localparam int unsigned KeyMax  = 50;
  localparam int unsigned IdleLimit = 200000;
  localparam logic [1:0]  ReqUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  kbyte;
    logic        last;
    logic [31:0] value;
  } word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [39:0] s_data = '0;
  logic [1:0]  s_user = '0;
  logic        s_last = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;
  logic [2:0]  m_user;

  sorted_string_table_search dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // table model
  logic [7:0]  tbl_key [Entries][KeyMax];
  int unsigned tbl_len [Entries];
  logic [31:0] tbl_val [Entries];
  int unsigned tbl_count = 0;
  logic [7:0]  asm_key [KeyMax];
  int unsigned asm_fill = 0;
  bit          asm_long = 0;

  word_t  pending_words[$];
  reply_t expected_replies[$];
  int     errors = 0;
  bit     stim_done = 0;
  int     idle_cycles = 0;

  // store the keys the random part loads, to search them again
  logic [7:0] known_keys [$][$];

  function automatic int cmp_entry(int unsigned e);
    int unsigned n;
    n = (tbl_len[e] < asm_fill) ? tbl_len[e] : asm_fill;
    for (int unsigned i = 0; i < n; i++)
      if (tbl_key[e][i] != asm_key[i]) return (tbl_key[e][i] < asm_key[i]) ? -1 : 1;
    if (tbl_len[e] == asm_fill) return 0;
    return (tbl_len[e] < asm_fill) ? -1 : 1;
  endfunction

  task automatic predict_word(word_t w);
    reply_t r;
    int lo, hi, mid, c;
    bit hit;
    if (w.req == ReqClear) begin
      tbl_count = 0; asm_fill = 0; asm_long = 0;
      return;
    end
    if (w.req == ReqUnused) return;
    if (asm_fill < KeyMax) begin
      asm_key[asm_fill] = w.kbyte;
      asm_fill++;
    end else asm_long = 1;
    if (!w.last) return;
    r = '0;
    if (w.req == ReqLoad) begin
      if (asm_long) r.status = StTooLong;
      else if (tbl_count >= Entries) r.status = StFull;
      else begin
        for (int unsigned i = 0; i < asm_fill; i++) tbl_key[tbl_count][i] = asm_key[i];
        tbl_len[tbl_count] = asm_fill;
        tbl_val[tbl_count] = w.value;
        tbl_count++;
        r.status = StLoaded;
      end
    end else begin
      hit = 0;
      r.status = StNotFound;
      if (!asm_long && tbl_count > 0) begin
        lo = 0; hi = int'(tbl_count) - 1;
        while (lo <= hi && !hit) begin
          mid = lo + (hi - lo) / 2;
          c = cmp_entry(mid);
          if (c == 0) begin
            hit = 1; r.status = StFound; r.value = tbl_val[mid];
          end else if (c < 0) lo = mid + 1;
          else hi = mid - 1;
        end
      end
    end
    expected_replies.push_back(r);
    asm_fill = 0; asm_long = 0;
  endtask

  task automatic put_word(logic [1:0] req, logic [7:0] b, logic last, logic [31:0] v);
    word_t w;
    w.req = req; w.kbyte = b; w.last = last; w.value = v;
    pending_words.push_back(w);
  endtask

  task automatic put_key(logic [1:0] req, logic [7:0] k[$], logic [31:0] v);
    for (int i = 0; i < k.size(); i++)
      put_word(req, k[i], i == k.size() - 1, (i == k.size() - 1) ? v : $urandom());
  endtask

  function automatic void random_key(ref logic [7:0] k[$], input int unsigned len);
    k.delete();
    // narrow alphabet most of the time so prefixes and near misses occur
    for (int unsigned i = 0; i < len; i++)
      k.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'($urandom_range(97, 100)));
  endfunction

  function automatic bit key_less(logic [7:0] a[$], logic [7:0] b[$]);
    int n;
    n = (a.size() < b.size()) ? a.size() : b.size();
    for (int i = 0; i < n; i++)
      if (a[i] != b[i]) return a[i] < b[i];
    return a.size() < b.size();
  endfunction

  // build a sorted table of n random keys and queue its load
  task automatic load_sorted(int unsigned n);
    logic [7:0] k[$];
    logic [7:0] tmp[$];
    int j;
    known_keys.delete();
    for (int unsigned i = 0; i < n; i++) begin
      random_key(k, $urandom_range(1, 6));
      known_keys.push_back(k);
    end
    for (int i = 1; i < known_keys.size(); i++) begin
      tmp = known_keys[i];
      j = i - 1;
      while (j >= 0 && key_less(tmp, known_keys[j])) begin
        known_keys[j + 1] = known_keys[j];
        j--;
      end
      known_keys[j + 1] = tmp;
    end
    put_word(ReqClear, 8'($urandom()), 1'($urandom()), $urandom());
    foreach (known_keys[i]) put_key(ReqLoad, known_keys[i], $urandom());
  endtask

  initial begin
    logic [7:0] k[$];
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed part
    k = '{8'h00}; put_key(ReqSearch, k, 0);                 // search an empty table
    k = '{8'h00}; put_key(ReqLoad, k, 32'h0);
    k = '{8'h61, 8'h62}; put_key(ReqLoad, k, 32'hFFFF_FFFF);
    k = '{8'h61, 8'h62, 8'h00}; put_key(ReqLoad, k, 32'hA5A5_5A5A); // prefix first
    k = '{8'hFF}; put_key(ReqLoad, k, 32'h1234_5678);
    k = '{8'h61, 8'h62}; put_key(ReqSearch, k, 0);
    k = '{8'h61}; put_key(ReqSearch, k, 0);
    k = '{8'hFF}; put_key(ReqSearch, k, 0);
    put_word(ReqUnused, 8'h55, 1'b1, 32'h5555_5555);         // unused request code
    put_word(ReqLoad, 8'h61, 1'b0, 0);                       // mixed types in one key
    put_word(ReqSearch, 8'h62, 1'b1, 0);
    put_word(ReqLoad, 8'h00, 1'b0, 0);                       // partial key dropped by clear
    put_word(ReqClear, 8'hFF, 1'b1, 32'hFFFF_FFFF);
    k = '{8'hFF}; put_key(ReqSearch, k, 0);
    // overlong keys: load and search, then the exact limit
    random_key(k, KeyMax + 1); put_key(ReqLoad, k, 1);
    random_key(k, KeyMax + 3); put_key(ReqSearch, k, 1);
    random_key(k, KeyMax); put_key(ReqLoad, k, 32'hCAFE_F00D);
    put_key(ReqSearch, k, 0);
    // fill the table and overflow it
    put_word(ReqClear, 0, 0, 0);
    for (int unsigned i = 0; i < Entries; i++) put_word(ReqLoad, 8'(i), 1'b1, i);
    put_word(ReqLoad, 8'h10, 1'b1, 7);
    put_word(ReqSearch, 8'h10, 1'b1, 0);
    put_word(ReqSearch, 8'hFF, 1'b1, 0);
    put_word(ReqClear, 0, 0, 0);

    // random part: sorted tables, searches of stored keys and misses, noise
    while (pending_words.size() < 1450) begin
      load_sorted($urandom_range(1, 24));
      repeat ($urandom_range(5, 15)) begin
        case ($urandom_range(0, 9))
          0: begin
            put_word($urandom_range(0, 3) == 0 ? ReqUnused : ReqSearch, 8'($urandom()),
                     1'($urandom()), $urandom());
          end
          1: begin
            random_key(k, $urandom_range(1, 5)); put_key(ReqLoad, k, $urandom());
          end
          2, 3: begin
            random_key(k, $urandom_range(1, 6)); put_key(ReqSearch, k, 0);
          end
          default: begin
            k = known_keys[$urandom_range(0, known_keys.size() - 1)];
            put_key(ReqSearch, k, $urandom());
          end
        endcase
      end
    end
    stim_done = 1;
  end

  bit s_ready_seen = 0;

  // sender: bursts and gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        // handshake already recorded on the rising edge
      end
      if (!s_valid || s_ready_seen) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          word_t w;
          w = pending_words.pop_front();
          s_user <= w.req;
          s_data <= {w.value, w.kbyte};
          s_last <= w.last;
          s_valid <= 1'b1;
          if (burst_left > 0) burst_left <= burst_left - 1;
          else begin
            burst_left <= $urandom_range(0, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else s_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern and acceptance tracking
  int stall_phase = 0;
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1;
    if ((stall_phase / 64) % 3 == 0) m_ready <= 1'b1;
    else m_ready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    bit accepted;
    accepted = 1'b0;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        word_t w;
        w.req = s_user; w.kbyte = s_data[7:0]; w.last = s_last; w.value = s_data[39:8];
        predict_word(w);
        accepted = 1'b1;
      end
      if (m_valid && m_ready) begin
        reply_t e;
        accepted = 1'b1;
        if (expected_replies.size() == 0) begin
          $error("unexpected word: status %0d value %h", m_user, m_data);
          errors++;
        end else begin
          e = expected_replies.pop_front();
          if (m_user !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, m_user);
            errors++;
          end
          if (m_data !== e.value) begin
            $error("found_value: expected %h actual %h", e.value, m_data);
            errors++;
          end
        end
      end
      idle_cycles <= accepted ? 0 : idle_cycles + 1;
    end
    s_ready_seen <= rst_ni && s_valid && s_ready;
  end

  initial begin
    wait (stim_done);
    while (!(pending_words.size() == 0 && !s_valid && expected_replies.size() == 0)
           && idle_cycles < IdleLimit)
      @(posedge clk_i);
    repeat (2000) @(posedge clk_i);
    if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
    end else if (errors == 0 && expected_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
